>>> src/sorted_alarm_deadline_queue_assert.svh
// assertion macros used by the top level alarm queue module
// no dependencies; define NO_ASSERTIONS to drop every check
`ifndef SORTED_ALARM_DEADLINE_QUEUE_ASSERT_SVH
`define SORTED_ALARM_DEADLINE_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SADQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SADQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SADQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SADQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/sadq_pkg.sv
// shared types and codes for the sorted alarm deadline queue
// no dependencies
package sadq_pkg;
    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_DEREGISTER = 2'd1;
    localparam logic [1:0] CMD_RING       = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [31:0] QUANTUM_RESET = 32'd100000;
    localparam logic [31:0] UPMS_RESET    = 32'd1000;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] deadline;
        logic        match_handle;
    } cell_cmd_t;
endpackage

>>> src/sadq_div.sv
// serial restoring divider: ceil(delay * units / quantum) in ticks
// depends on sadq_pkg only through its users; no package items used here
module sadq_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] delay,
    input  logic [31:0] units,
    input  logic [31:0] quantum,
    output logic        done,
    output logic [47:0] ticks
);
    logic [47:0] prod_reg, prod_next;
    logic [47:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // one quotient bit per cycle
    always_comb
    begin
        prod_next = prod_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], prod_reg[47]};
        if (start)
        begin
            prod_next = {16'd0, 32'd0} | (48'(delay) * 48'(units));
            q_next    = (quantum == 32'd0) ? 32'd1 : quantum;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = {prod_reg[46:0], 1'b0};
            if (trial >= {1'b0, q_reg})
            begin
                rem_next = trial - {1'b0, q_reg};
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign done  = done_reg;
    assign ticks = quo_reg + ((rem_reg != 33'd0) ? 48'd1 : 48'd0);
endmodule

>>> src/sadq_cell.sv
// one slot of the sorted chain: holds deadline, tag and handle
// depends on sadq_pkg for the cell command struct
module sadq_cell #(
    parameter int TAG_WIDTH = 32,
    parameter int HW        = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sadq_pkg::cell_cmd_t   cmd,
    input  logic [HW-1:0]         new_handle,
    input  logic [TAG_WIDTH-1:0]  new_tag,
    // left neighbor, toward the head
    input  logic                  left_valid,
    input  logic                  left_ins,
    input  logic                  left_rm,
    input  logic [31:0]           left_deadline,
    input  logic [TAG_WIDTH-1:0]  left_tag,
    input  logic [HW-1:0]         left_handle,
    // right neighbor, toward the tail
    input  logic                  right_valid,
    input  logic [31:0]           right_deadline,
    input  logic [TAG_WIDTH-1:0]  right_tag,
    input  logic [HW-1:0]         right_handle,
    output logic                  valid,
    output logic                  ins,
    output logic                  rm,
    output logic [31:0]           deadline,
    output logic [TAG_WIDTH-1:0]  tag,
    output logic [HW-1:0]         handle
);
    logic                 valid_reg, valid_next;
    logic [31:0]          dl_reg, dl_next;
    logic [TAG_WIDTH-1:0] tag_reg, tag_next;
    logic [HW-1:0]        hd_reg, hd_next;
    logic                 here_ge, here_hit;

    // insert point is the first valid cell with deadline >= new, or first empty
    assign here_ge  = !valid_reg || (dl_reg >= cmd.deadline);
    assign ins      = left_ins || here_ge;
    assign here_hit = valid_reg && (cmd.match_handle ? (hd_reg == new_handle) : 1'b1);
    assign rm       = left_rm || here_hit;

    always_comb
    begin
        valid_next = valid_reg;
        dl_next    = dl_reg;
        tag_next   = tag_reg;
        hd_next    = hd_reg;
        case (cmd.op)
            sadq_pkg::OP_INSERT:
            begin
                if (left_ins)
                begin
                    valid_next = left_valid;
                    dl_next    = left_deadline;
                    tag_next   = left_tag;
                    hd_next    = left_handle;
                end
                else if (here_ge)
                begin
                    valid_next = 1'b1;
                    dl_next    = cmd.deadline;
                    tag_next   = new_tag;
                    hd_next    = new_handle;
                end
            end
            sadq_pkg::OP_REMOVE:
            begin
                if (rm)
                begin
                    valid_next = right_valid;
                    dl_next    = right_deadline;
                    tag_next   = right_tag;
                    hd_next    = right_handle;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        dl_reg  <= dl_next;
        tag_reg <= tag_next;
        hd_reg  <= hd_next;
    end

    assign valid    = valid_reg;
    assign deadline = dl_reg;
    assign tag      = tag_reg;
    assign handle   = hd_reg;
endmodule

>>> src/sorted_alarm_deadline_queue.sv
// top level of the sorted alarm deadline queue: control, divider, cell chain
// depends on sadq_pkg, sadq_div, sadq_cell and the assertion header
// sequence: register runs the 48-step serial divider, then apply, done and output;
//   deregister and ring go straight to apply; one item in flight at a time
// a new item is taken only after the previous result has been transferred
// reset: queue empty, all handles free, config at 100000 and 1000
`include "sorted_alarm_deadline_queue_assert.svh"
module sorted_alarm_deadline_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_WIDTH   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [15:0] delay_ms,
    input  logic [31:0] alarm_tag,
    input  logic [3:0]  handle_in,
    input  logic [31:0] now_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  handle_out,
    output logic [31:0] fired_tag,
    output logic [31:0] head_deadline,
    output logic        head_valid
);
    localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [31:0] quantum_reg, upms_reg;
    logic [1:0]  cmd_reg;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic [3:0]  hin_reg;
    logic [31:0] now_reg;
    logic [31:0] dl_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [QUEUE_DEPTH-1:0] used_reg, used_next;
    logic [HW-1:0] free_h;
    logic        free_ok;
    logic [1:0]  status_reg;
    logic [3:0]  hout_reg;
    logic [31:0] fired_reg;
    logic        div_start, div_done;
    logic [47:0] div_ticks;
    logic [48:0] dl_sum;
    logic        hin_ok, found;
    sadq_pkg::cell_cmd_t cmd;

    logic [QUEUE_DEPTH:0]  c_valid, c_ins, c_rm;
    logic [31:0]           c_dl  [QUEUE_DEPTH+1];
    logic [TAG_WIDTH-1:0]  c_tag [QUEUE_DEPTH+1];
    logic [HW-1:0]         c_hd  [QUEUE_DEPTH+1];

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= sadq_pkg::QUANTUM_RESET;
            upms_reg    <= sadq_pkg::UPMS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == 1'b0)
                quantum_reg <= cfg_data;
            else
                upms_reg <= cfg_data;
        end
    end

    // divider starts at the input transfer, so it takes the delay from the port
    sadq_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .delay   (delay_ms),
        .units   (upms_reg),
        .quantum (quantum_reg),
        .done    (div_done),
        .ticks   (div_ticks)
    );

    assign dl_sum = 49'(now_reg) + 49'(div_ticks);

    // lowest free handle
    always_comb
    begin
        free_h  = '0;
        free_ok = 1'b0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_h  = HW'(i);
                free_ok = 1'b1;
            end
        end
    end

    assign hin_ok = (32'(hin_reg) < QUEUE_DEPTH) && used_reg[HW'(hin_reg)];

    // cell chain, boundary at both ends
    assign c_ins[0]   = 1'b0;
    assign c_rm[0]    = 1'b0;
    assign c_valid[0] = 1'b0;
    assign c_dl[0]    = '0;
    assign c_tag[0]   = '0;
    assign c_hd[0]    = '0;

    logic [QUEUE_DEPTH-1:0] cv, cins, crm;
    logic [31:0]          cdl  [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0] ctag [QUEUE_DEPTH];
    logic [HW-1:0]        chd  [QUEUE_DEPTH];

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic                 rv;
            logic [31:0]          rdl;
            logic [TAG_WIDTH-1:0] rtag;
            logic [HW-1:0]        rhd;
            if (g == QUEUE_DEPTH - 1)
            begin : g_end
                assign rv = 1'b0;  assign rdl = '0;
                assign rtag = '0;  assign rhd = '0;
            end
            else
            begin : g_mid
                assign rv = cv[g+1];   assign rdl = cdl[g+1];
                assign rtag = ctag[g+1]; assign rhd = chd[g+1];
            end
            sadq_cell #(.TAG_WIDTH(TAG_WIDTH), .HW(HW)) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .cmd            (cmd),
                .new_handle     ((cmd.op == sadq_pkg::OP_INSERT) ? free_h : HW'(hin_reg)),
                .new_tag        (tag_reg),
                .left_valid     (c_valid[g]),
                .left_ins       (c_ins[g]),
                .left_rm        (c_rm[g]),
                .left_deadline  (c_dl[g]),
                .left_tag       (c_tag[g]),
                .left_handle    (c_hd[g]),
                .right_valid    (rv),
                .right_deadline (rdl),
                .right_tag      (rtag),
                .right_handle   (rhd),
                .valid          (cv[g]),
                .ins            (cins[g]),
                .rm             (crm[g]),
                .deadline       (cdl[g]),
                .tag            (ctag[g]),
                .handle         (chd[g])
            );
            assign c_valid[g+1] = cv[g];
            assign c_ins[g+1]   = cins[g];
            assign c_rm[g+1]    = crm[g];
            assign c_dl[g+1]    = cdl[g];
            assign c_tag[g+1]   = ctag[g];
            assign c_hd[g+1]    = chd[g];
        end
    endgenerate

    assign found = c_rm[QUEUE_DEPTH];

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = sadq_pkg::OP_HOLD;
        cmd.deadline = dl_reg;
        cmd.match_handle = (cmd_reg == sadq_pkg::CMD_DEREGISTER);
        count_next   = count_reg;
        used_next    = used_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = (command == sadq_pkg::CMD_REGISTER) ? S_DIV : S_APPLY;
            S_DIV:
                if (div_done)
                    state_next = S_APPLY;
            S_APPLY:
            begin
                case (cmd_reg)
                    sadq_pkg::CMD_REGISTER:
                        if (32'(count_reg) < QUEUE_DEPTH && free_ok)
                        begin
                            cmd.op = sadq_pkg::OP_INSERT;
                            count_next = count_reg + CW'(1);
                            used_next[free_h] = 1'b1;
                        end
                    sadq_pkg::CMD_DEREGISTER:
                        if (hin_ok)
                        begin
                            cmd.op = sadq_pkg::OP_REMOVE;
                            count_next = count_reg - CW'(1);
                            used_next[HW'(hin_reg)] = 1'b0;
                        end
                    sadq_pkg::CMD_RING:
                        if (count_reg != '0)
                        begin
                            cmd.op = sadq_pkg::OP_REMOVE;
                            count_next = count_reg - CW'(1);
                            used_next[chd[0]] = 1'b0;
                        end
                    default:
                    begin
                    end
                endcase
                state_next = S_DONE;
            end
            S_DONE:
                state_next = S_OUT;
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg == S_DIV && div_done)
            cmd.deadline = dl_sum[48:32] != '0 ? 32'hFFFF_FFFF : dl_sum[31:0];
    end

    assign div_start = 1'b0 | (state_reg == S_IDLE && in_valid &&
                               command == sadq_pkg::CMD_REGISTER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            used_reg  <= used_next;
        end
    end

    // captured item, deadline and result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= command;
            tag_reg   <= TAG_WIDTH'(alarm_tag);
            hin_reg   <= handle_in;
            now_reg   <= now_ticks;
        end
        if (state_reg == S_DIV && div_done)
            dl_reg <= (dl_sum[48:32] != '0) ? 32'hFFFF_FFFF : dl_sum[31:0];
        if (state_reg == S_APPLY)
        begin
            status_reg <= sadq_pkg::ST_OK;
            hout_reg   <= '0;
            fired_reg  <= '0;
            case (cmd_reg)
                sadq_pkg::CMD_REGISTER:
                    if (32'(count_reg) < QUEUE_DEPTH && free_ok)
                        hout_reg <= 4'(free_h);
                    else
                        status_reg <= sadq_pkg::ST_FULL;
                sadq_pkg::CMD_DEREGISTER:
                    if (!hin_ok)
                        status_reg <= sadq_pkg::ST_NOT_FOUND;
                sadq_pkg::CMD_RING:
                    if (count_reg == '0)
                        status_reg <= sadq_pkg::ST_EMPTY;
                    else
                        fired_reg <= 32'(ctag[0]);
                default:
                begin
                end
            endcase
        end
    end

    assign status        = status_reg;
    assign handle_out    = hout_reg;
    assign fired_tag     = fired_reg;
    assign head_valid    = cv[0];
    assign head_deadline = cv[0] ? cdl[0] : 32'd0;

    `SADQ_ASSERT_IMP(a_count_match, clk, rst_n, 1'b1, (count_reg != '0) == cv[0])
    `SADQ_ASSERT_IMP(a_used_count, clk, rst_n, 1'b1, $countones(used_reg) == 32'(count_reg))
    `SADQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `SADQ_ASSERT_IMP(a_found, clk, rst_n,
        state_reg == S_APPLY && cmd_reg == sadq_pkg::CMD_DEREGISTER && hin_ok, found)
endmodule

>>> tb/sorted_alarm_deadline_queue_tb.sv
// self-checking testbench for the sorted alarm deadline queue
// depends on sadq_pkg and sorted_alarm_deadline_queue; drives directed then random traffic
module sorted_alarm_deadline_queue_tb;

    localparam int          DEPTH      = 16;
    localparam logic        REG_QUANTUM = 1'b0;
    localparam logic        REG_UPMS    = 1'b1;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          STALL_LIMIT = 4000;
    localparam int          PHASE_ITEMS = 330;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] delay;
        logic [31:0] tag;
        logic [3:0]  hdl;
        logic [31:0] now;
    } alarm_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  handle_out;
        logic [31:0] fired_tag;
        logic [31:0] head_deadline;
        logic        head_valid;
    } alarm_result_t;

    typedef struct packed {
        alarm_cmd_t    c;
        logic          typed;
        alarm_result_t r;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [15:0] delay_ms;
    logic [31:0] alarm_tag;
    logic [3:0]  handle_in;
    logic [31:0] now_ticks;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [3:0]  handle_out;
    logic [31:0] fired_tag;
    logic [31:0] head_deadline;
    logic        head_valid;

    // shadow copy of the queue and the timing registers
    logic [31:0] pend_deadline [DEPTH];
    logic [31:0] pend_tag      [DEPTH];
    logic [3:0]  pend_handle   [DEPTH];
    int          pend_count;
    logic [DEPTH-1:0] handle_used;
    logic [31:0] quantum_cfg;
    logic [31:0] upms_cfg;

    alarm_result_t pending_results[$];
    stim_row_t     directed_rows[$];
    int            error_count;
    logic          no_idle;

    sorted_alarm_deadline_queue u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .delay_ms      (delay_ms),
        .alarm_tag     (alarm_tag),
        .handle_in     (handle_in),
        .now_ticks     (now_ticks),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .handle_out    (handle_out),
        .fired_tag     (fired_tag),
        .head_deadline (head_deadline),
        .head_valid    (head_valid)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // drop one slot and close the gap
    function automatic void drop_slot(int pos);
        int i;
        handle_used[pend_handle[pos]] = 1'b0;
        for (i = pos; i + 1 < pend_count; i++)
        begin
            pend_deadline[i] = pend_deadline[i+1];
            pend_tag[i]      = pend_tag[i+1];
            pend_handle[i]   = pend_handle[i+1];
        end
        pend_count--;
    endfunction

    // apply one command to the shadow queue and return the expected answer
    function automatic alarm_result_t apply_alarm_cmd(alarm_cmd_t c);
        alarm_result_t r;
        logic [63:0]   q;
        logic [63:0]   prod;
        logic [63:0]   ticks;
        logic [63:0]   sum;
        logic [31:0]   dead;
        int            pos;
        int            h;
        int            i;
        r = '0;
        case (c.cmd)
            sadq_pkg::CMD_REGISTER:
            begin
                h = 0;
                while (h < DEPTH && handle_used[h])
                    h++;
                if (pend_count >= DEPTH || h >= DEPTH)
                    r.status = sadq_pkg::ST_FULL;
                else
                begin
                    q     = (quantum_cfg == 0) ? 64'd1 : {32'd0, quantum_cfg};
                    prod  = {48'd0, c.delay} * {32'd0, upms_cfg};
                    ticks = prod / q + (((prod % q) != 0) ? 64'd1 : 64'd0);
                    sum   = {32'd0, c.now} + ticks;
                    dead  = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                    pos = 0;
                    while (pos < pend_count && pend_deadline[pos] < dead)
                        pos++;
                    for (i = pend_count; i > pos; i--)
                    begin
                        pend_deadline[i] = pend_deadline[i-1];
                        pend_tag[i]      = pend_tag[i-1];
                        pend_handle[i]   = pend_handle[i-1];
                    end
                    pend_deadline[pos] = dead;
                    pend_tag[pos]      = c.tag;
                    pend_handle[pos]   = h[3:0];
                    handle_used[h]     = 1'b1;
                    pend_count++;
                    r.handle_out = h[3:0];
                end
            end
            sadq_pkg::CMD_DEREGISTER:
            begin
                r.status = sadq_pkg::ST_NOT_FOUND;
                for (i = 0; i < pend_count; i++)
                begin
                    if (pend_handle[i] == c.hdl)
                    begin
                        drop_slot(i);
                        r.status = sadq_pkg::ST_OK;
                        break;
                    end
                end
            end
            sadq_pkg::CMD_RING:
            begin
                if (pend_count == 0)
                    r.status = sadq_pkg::ST_EMPTY;
                else
                begin
                    r.fired_tag = pend_tag[0];
                    drop_slot(0);
                end
            end
            default:
                r.status = sadq_pkg::ST_OK;
        endcase
        r.head_deadline = (pend_count != 0) ? pend_deadline[0] : 32'd0;
        r.head_valid    = (pend_count != 0);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got, want);
        error_count++;
    endtask

    // send one command, with a random gap first unless no_idle is set
    task automatic send_alarm_cmd(alarm_cmd_t c, logic typed, alarm_result_t typed_r);
        int            gap;
        alarm_result_t r;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= c.cmd;
        delay_ms  <= c.delay;
        alarm_tag <= c.tag;
        handle_in <= c.hdl;
        now_ticks <= c.now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // transfer done at this edge
        r = apply_alarm_cmd(c);
        pending_results.push_back(typed ? typed_r : r);
    endtask

    // config writes happen only with the block drained
    task automatic write_reg(logic idx, logic [31:0] value);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_QUANTUM)
            quantum_cfg = value;
        else
            upms_cfg = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_row(logic [1:0] cmd, logic [15:0] delay, logic [31:0] tag,
                                    logic [3:0] hdl, logic [31:0] now, logic typed,
                                    alarm_result_t r);
        stim_row_t row;
        row.c     = '{cmd, delay, tag, hdl, now};
        row.typed = typed;
        row.r     = r;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [31:0] rand_now();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 5000);
            default: return $urandom_range(0, 20000);
        endcase
    endfunction

    function automatic alarm_cmd_t rand_alarm_cmd(int reg_weight);
        alarm_cmd_t c;
        int         pick;
        c.tag   = $urandom();
        c.now   = rand_now();
        c.delay = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 600));
        c.hdl   = 4'($urandom());
        pick    = $urandom_range(0, 99);
        if (pick < reg_weight)
            c.cmd = sadq_pkg::CMD_REGISTER;
        else if (pick < reg_weight + (100 - reg_weight) / 2)
        begin
            c.cmd = sadq_pkg::CMD_DEREGISTER;
            // mostly aim at a live handle
            if (pend_count > 0 && $urandom_range(0, 4) != 0)
                c.hdl = pend_handle[$urandom_range(0, pend_count - 1)];
        end
        else if (pick < 97)
            c.cmd = sadq_pkg::CMD_RING;
        else
            c.cmd = CMD_UNUSED;
        return c;
    endfunction

    // result side: random backpressure and compare against the oldest expectation
    initial
    begin
        alarm_result_t want;
        int            stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 32'd1, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (handle_out !== want.handle_out)
                    report_mismatch("handle_out", handle_out, want.handle_out);
                if (fired_tag !== want.fired_tag)
                    report_mismatch("fired_tag", fired_tag, want.fired_tag);
                if (head_deadline !== want.head_deadline)
                    report_mismatch("head_deadline", head_deadline, want.head_deadline);
                if (head_valid !== want.head_valid)
                    report_mismatch("head_valid", head_valid, want.head_valid);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // main sequence
    initial
    begin
        alarm_result_t none;
        logic [31:0]   q_set [6];
        logic [31:0]   u_set [6];
        int            i;
        int            p;
        int            reg_weight;
        none        = '0;
        error_count = 0;
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_QUANTUM;
        cfg_data    = '0;
        in_valid    = 1'b0;
        command     = sadq_pkg::CMD_REGISTER;
        delay_ms    = '0;
        alarm_tag   = '0;
        handle_in   = '0;
        now_ticks   = '0;
        pend_count  = 0;
        handle_used = '0;
        quantum_cfg = sadq_pkg::QUANTUM_RESET;
        upms_cfg    = sadq_pkg::UPMS_RESET;

        // directed table; typed rows hold the answer as read off the spec
        add_row(sadq_pkg::CMD_RING, 16'd0, 32'd0, 4'd0, 32'd0, 1'b1,
                '{sadq_pkg::ST_EMPTY, 4'd0, 32'd0, 32'd0, 1'b0});
        add_row(sadq_pkg::CMD_DEREGISTER, 16'd0, 32'd0, 4'd15, 32'd0, 1'b1,
                '{sadq_pkg::ST_NOT_FOUND, 4'd0, 32'd0, 32'd0, 1'b0});
        add_row(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 1'b1, none);
        add_row(sadq_pkg::CMD_REGISTER, 16'd0, 32'd0, 4'd0, 32'd0, 1'b1,
                '{sadq_pkg::ST_OK, 4'd0, 32'd0, 32'd0, 1'b1});
        // deadline saturates at the top of the range
        add_row(sadq_pkg::CMD_REGISTER, 16'hFFFF, 32'hFFFF_FFFF, 4'd0, 32'hFFFF_FFFF, 1'b1,
                '{sadq_pkg::ST_OK, 4'd1, 32'd0, 32'd0, 1'b1});
        // fill the rest, with repeated deadlines to check ties
        for (i = 0; i < DEPTH - 2; i++)
            add_row(sadq_pkg::CMD_REGISTER, 16'((i % 3) * 150 + 1), 32'hA5A5_0000 + i, 4'd0,
                    32'd5, 1'b0, none);
        // one more register on a full queue
        add_row(sadq_pkg::CMD_REGISTER, 16'd7, 32'h1234_5678, 4'd0, 32'd0, 1'b1,
                '{sadq_pkg::ST_FULL, 4'd0, 32'd0, 32'd0, 1'b1});
        add_row(sadq_pkg::CMD_RING, 16'd0, 32'd0, 4'd0, 32'd0, 1'b0, none);
        add_row(sadq_pkg::CMD_DEREGISTER, 16'd0, 32'd0, 4'd1, 32'd0, 1'b0, none);
        add_row(sadq_pkg::CMD_DEREGISTER, 16'd0, 32'd0, 4'd1, 32'd0, 1'b0, none);
        add_row(sadq_pkg::CMD_RING, 16'd0, 32'd0, 4'd0, 32'd0, 1'b0, none);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_alarm_cmd(directed_rows[k].c, directed_rows[k].typed, directed_rows[k].r);

        // register settings per phase, extremes included (zero quantum counts as one)
        q_set = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd100000, 32'd0};
        u_set = '{32'd1, 32'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1000, 32'd0};
        for (p = 0; p < 6; p++)
        begin
            if (p == 5)
            begin
                q_set[p] = $urandom();
                u_set[p] = $urandom();
            end
            write_reg(REG_QUANTUM, q_set[p]);
            write_reg(REG_UPMS, u_set[p]);
            no_idle    = (p == 2);
            reg_weight = (p % 2 == 0) ? 55 : 40;
            for (i = 0; i < PHASE_ITEMS; i++)
                send_alarm_cmd(rand_alarm_cmd(reg_weight), 1'b0, none);
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        wait (pending_results.size() == 0);
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
